@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ hw/rtl/eds_pkg.sv @@
// ----------------------------------------------------------------------------
// eds_pkg
// Types and constants of the Euclidean distance stream.
// ----------------------------------------------------------------------------
package eds_pkg;

    localparam int RANK_W    = 16;
    localparam int SUM_BITS  = 44;
    localparam int ROOT_BITS = 22;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int ROOT_CNT_W = 5;

    typedef struct packed {
        logic [RANK_W-1:0] rank_a;
        logic [RANK_W-1:0] rank_b;
        logic              last;
    } eds_in_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] distance;
        logic                 saturated;
    } eds_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_START,
        ST_ROOT
    } eds_state_t;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] radicand;
    } eds_root_req_t;

    typedef struct packed {
        logic                 busy;
        logic [ROOT_BITS-1:0] root;
    } eds_root_sts_t;

endpackage

@@ hw/rtl/eds_sqrt.sv @@
// ----------------------------------------------------------------------------
// eds_sqrt
// Bit-serial floor square root: one result bit per cycle, two radicand bits in.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eds_sqrt
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  eds_pkg::eds_root_req_t req,
    output eds_pkg::eds_root_sts_t sts
);

    logic                               busy_reg, busy_next;
    logic [eds_pkg::ROOT_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [eds_pkg::SUM_BITS-1:0]       rad_reg, rad_next;
    logic [eds_pkg::REM_BITS-1:0]       rem_reg, rem_next;
    logic [eds_pkg::ROOT_BITS-1:0]      root_reg, root_next;
    logic [eds_pkg::REM_BITS+1:0]       rem_shift;
    logic [eds_pkg::REM_BITS+1:0]       trial;
    logic [eds_pkg::REM_BITS+1:0]       rem_diff;
    logic                               fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_shift = {rem_reg, rad_reg[eds_pkg::SUM_BITS-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = eds_pkg::ROOT_CNT_W'(eds_pkg::ROOT_BITS - 1);
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[eds_pkg::SUM_BITS-3:0], 2'b00};
            if (fits)
            begin
                rem_next  = rem_diff[eds_pkg::REM_BITS-1:0];
                root_next = {root_reg[eds_pkg::ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[eds_pkg::REM_BITS-1:0];
                root_next = {root_reg[eds_pkg::ROOT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.root = root_reg;

    `ASSERT_NEVER(a_start_while_busy, req.start && busy_reg)
    `ASSERT_CLK(a_busy_after_start, req.start |=> busy_reg)
    `ASSERT_CLK(a_cnt_in_range, busy_reg |-> cnt_reg < eds_pkg::ROOT_CNT_W'(eds_pkg::ROOT_BITS))

endmodule

@@ hw/rtl/euclidean_distance_stream.sv @@
// ----------------------------------------------------------------------------
// euclidean_distance_stream
// Streamed Euclidean distance of two rank vectors in half-rank units.
// ----------------------------------------------------------------------------
// Input channel pair_valid / pair_stall / pair: one transaction carries one
// element of each rank vector (unsigned, one fractional bit) and a last flag.
// Output channel dist_valid / dist_stall / dist_data: one transaction per
// vector pair, floor of the root of the summed squared differences, plus a
// flag set when the 44-bit sum saturated.
// Each element pair is squared by a shift-add multiplier, one bit per cycle,
// then added to the sum. On the last element the sum is handed to the root
// unit, which runs one result bit per cycle; the root is then loaded into the
// output register, and the next vector starts once it is loaded.
// pair_stall is high whenever an element is in work.
// Reset clears the sum, the saturation flag and the result valid flag.
// A stalled result holds in the output register; new elements are still taken,
// and only the loading of the next result waits for it to leave.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euclidean_distance_stream
#(
    parameter int RANK_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  eds_pkg::eds_in_t pair,
    output logic             dist_valid,
    input  logic             dist_stall,
    output eds_pkg::eds_out_t dist_data
);

    localparam int EFF_BITS = (RANK_BITS < eds_pkg::RANK_W) ? RANK_BITS : eds_pkg::RANK_W;
    localparam int PROD_W   = 2 * EFF_BITS;
    localparam int CNT_W    = $clog2(EFF_BITS);

    eds_pkg::eds_state_t          state_reg, state_next;
    logic [eds_pkg::SUM_BITS-1:0] sum_reg, sum_next;
    logic                         ovf_reg, ovf_next;
    logic                         sat_hold_reg, sat_hold_next;
    logic                         last_reg, last_next;
    logic [PROD_W-1:0]            mcand_reg, mcand_next;
    logic [EFF_BITS-1:0]          mplier_reg, mplier_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    eds_pkg::eds_out_t            out_reg, out_next;

    logic [EFF_BITS-1:0]          a_val, b_val, abs_diff;
    logic [eds_pkg::SUM_BITS:0]   sum_wide;
    eds_pkg::eds_root_req_t       root_req;
    eds_pkg::eds_root_sts_t       root_sts;
    logic                         accept;

    eds_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .sts   (root_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eds_pkg::ST_IDLE;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_hold_reg <= sat_hold_next;
        last_reg     <= last_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        cnt_reg      <= cnt_next;
        out_reg      <= out_next;
    end

    assign a_val    = pair.rank_a[EFF_BITS-1:0];
    assign b_val    = pair.rank_b[EFF_BITS-1:0];
    assign abs_diff = (a_val >= b_val) ? (a_val - b_val) : (b_val - a_val);
    assign accept   = pair_valid && !pair_stall;
    assign sum_wide = {1'b0, sum_reg} + (eds_pkg::SUM_BITS + 1)'(prod_reg);

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        sat_hold_next   = sat_hold_reg;
        last_next       = last_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        prod_next       = prod_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && dist_stall;
        root_req.start    = 1'b0;
        root_req.radicand = sum_reg;
        pair_stall      = (state_reg != eds_pkg::ST_IDLE);

        unique case (state_reg)
            eds_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mcand_next  = PROD_W'(abs_diff);
                    mplier_next = abs_diff;
                    prod_next   = '0;
                    cnt_next    = '0;
                    last_next   = pair.last;
                    state_next  = eds_pkg::ST_MUL;
                end
            end
            eds_pkg::ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[EFF_BITS-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(EFF_BITS - 1))
                begin
                    state_next = eds_pkg::ST_ACC;
                end
            end
            eds_pkg::ST_ACC:
            begin
                if (sum_wide[eds_pkg::SUM_BITS])
                begin
                    sum_next = '1;
                    ovf_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_wide[eds_pkg::SUM_BITS-1:0];
                end
                state_next = last_reg ? eds_pkg::ST_START : eds_pkg::ST_IDLE;
            end
            eds_pkg::ST_START:
            begin
                root_req.start = 1'b1;
                sat_hold_next  = ovf_reg;
                sum_next       = '0;
                ovf_next       = 1'b0;
                state_next     = eds_pkg::ST_ROOT;
            end
            eds_pkg::ST_ROOT:
            begin
                if (!root_sts.busy && !(out_valid_reg && dist_stall))
                begin
                    out_next.distance  = root_sts.root;
                    out_next.saturated = sat_hold_reg;
                    out_valid_next     = 1'b1;
                    state_next         = eds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eds_pkg::ST_IDLE;
            end
        endcase
    end

    assign dist_valid = out_valid_reg;
    assign dist_data  = out_reg;

    `ASSERT_CLK(a_result_from_root, $rose(out_valid_reg) |-> $past(state_reg) == eds_pkg::ST_ROOT)
    `ASSERT_CLK(a_root_idle_in_mul, state_reg == eds_pkg::ST_MUL |-> !root_sts.busy)
    `ASSERT_CLK(a_sum_cleared, state_reg == eds_pkg::ST_START |=> sum_reg == '0 && !ovf_reg)
    `ASSERT_CLK(a_ovf_pins_sum, ovf_reg |-> sum_reg == {eds_pkg::SUM_BITS{1'b1}})

endmodule
